>>> sv/bss_pkg.sv
// Shared types and constants for the bounded set store.
package bss_pkg;

    localparam int SET_DEPTH = 64;
    localparam int IDX_W     = $clog2(SET_DEPTH);
    localparam int CNT_W     = $clog2(SET_DEPTH + 1);
    localparam int VAL_W     = 32;
    localparam int SUM_W     = VAL_W + $clog2(SET_DEPTH);
    localparam int CAP_W     = 7;
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int STEP_W    = $clog2(SUM_W);

    localparam int ADDR_W    = 3;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam int DATA_W    = 32;

    localparam logic [REG_IDX_W-1:0] REG_CAPACITY   = '0;
    localparam logic [CAP_W-1:0]     CAPACITY_RESET = 7'd64;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_DUP      = 2'd2;
    localparam logic [1:0] ST_LOOKUP   = 2'd3;

    typedef struct packed {
        logic                    kind;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]              status;
        logic                    found;
        logic [CAP_W-1:0]        element_count;
        logic                    is_empty;
        logic signed [VAL_W-1:0] mean_value;
        logic [VAL_W-1:0]        spread;
    } t_out_item;

    // Search key and running match flag moving down the cell row.
    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] key;
    } t_probe;

endpackage

>>> sv/bss_cell.sv
// One storage cell of the set: holds an element and checks the passing key.
module bss_cell (
    input  logic            i_clk,
    input  logic            i_live,
    input  logic            i_wr,
    input  bss_pkg::t_probe i_probe,
    output bss_pkg::t_probe o_probe
);
    import bss_pkg::*;

    logic [VAL_W-1:0] r_entry;
    t_probe           r_probe;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_entry <= i_probe.key;
        end
        r_probe.key <= i_probe.key;
        r_probe.hit <= i_probe.hit | (i_live & (r_entry == i_probe.key));
    end

    assign o_probe = r_probe;

endmodule

>>> sv/bss_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module bss_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [bss_pkg::SUM_W-1:0] i_dividend,
    input  logic [bss_pkg::CNT_W-1:0]      i_divisor,
    output logic                           o_done,
    output logic signed [bss_pkg::VAL_W-1:0] o_quotient
);
    import bss_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic              r_neg;
    logic [SUM_W-1:0]  r_dq;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;

    logic [CNT_W:0]    w_trial;
    logic              w_qbit;
    logic [SUM_W-1:0]  w_mag;
    logic [SUM_W-1:0]  w_signed_q;

    assign w_mag   = i_dividend[SUM_W-1] ? (SUM_W'(0) - SUM_W'(i_dividend))
                                         : SUM_W'(i_dividend);
    assign w_trial = {r_rem, r_dq[SUM_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_dq  <= w_mag;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_dq  <= {r_dq[SUM_W-2:0], w_qbit};
            r_rem <= w_qbit ? CNT_W'(w_trial - {1'b0, r_div}) : w_trial[CNT_W-1:0];
        end
    end

    assign w_signed_q = r_neg ? (SUM_W'(0) - r_dq) : r_dq;
    assign o_quotient = w_signed_q[VAL_W-1:0];
    assign o_done     = r_done;

endmodule

>>> sv/bounded_set_store_core.sv
// Top level of the bounded set store: controller, cell row and register port.
//
// Input channel: i_in_valid / o_in_stall with i_in_data (kind, value). A
// transaction is taken at a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall with o_out_data; one result per
// input transaction, in order.
// Items are handled one at a time. The search key walks the row of
// SET_DEPTH cells, one cell per cycle, for the membership check; the state
// update follows, and the mean comes from a radix-2 divider. The next item
// is accepted once the block is idle again.
// Reset (synchronous, active low) empties the set and sets capacity to 64.
// Capacity is written through the APB port at byte address 0; the user must
// write it only while idle, as the block itself does not enforce this.
// A finished result sits in an output register, so a new item can be
// worked on while the receiver stalls; the block then holds its next
// result until the output register frees up.
module bounded_set_store_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  bss_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output bss_pkg::t_out_item              o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bss_pkg::ADDR_W-1:0]      paddr,
    input  logic [bss_pkg::DATA_W-1:0]      pwdata,
    output logic [bss_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import bss_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_UPDATE  = 3'd2;
    localparam logic [2:0] S_DIVGO   = 3'd3;
    localparam logic [2:0] S_DIVWAIT = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0]              r_state, n_state;
    logic [IDX_W-1:0]        r_scan, n_scan;
    logic                    r_kind;
    logic [VAL_W-1:0]        r_key;
    logic [CNT_W-1:0]        r_count, n_count;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic signed [VAL_W-1:0] r_min, n_min;
    logic signed [VAL_W-1:0] r_max, n_max;
    logic [CAP_W-1:0]        r_capacity;
    logic [1:0]              r_status, n_status;
    logic                    r_found, n_found;
    logic signed [VAL_W-1:0] r_mean, n_mean;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out;

    t_probe                  w_probe [SET_DEPTH+1];
    logic [SET_DEPTH-1:0]    w_live;
    logic [SET_DEPTH-1:0]    w_wr;
    logic                    w_accept;
    logic                    w_full;
    logic                    w_insert;
    logic                    w_move_out;
    logic [CMP_W-1:0]        w_cap_ext;
    logic [CMP_W-1:0]        w_limit;
    logic signed [VAL_W-1:0] w_val;
    logic                    w_div_done;
    logic signed [VAL_W-1:0] w_quot;
    logic                    w_cfg_wr;

    // ---- register port ----
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready &
                      (paddr[ADDR_W-1:2] == REG_CAPACITY);
    assign prdata   = (paddr[ADDR_W-1:2] == REG_CAPACITY) ? DATA_W'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (w_cfg_wr) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    // ---- cell row ----
    assign w_probe[0].hit = 1'b0;
    assign w_probe[0].key = r_key;

    for (genvar g = 0; g < SET_DEPTH; g++) begin : g_cell
        assign w_live[g] = (CNT_W'(g) < r_count);
        assign w_wr[g]   = w_insert & (r_count == CNT_W'(g));
        bss_cell u_cell (
            .i_clk   (i_clk),
            .i_live  (w_live[g]),
            .i_wr    (w_wr[g]),
            .i_probe (w_probe[g]),
            .o_probe (w_probe[g+1])
        );
    end

    // ---- mean ----
    bss_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIVGO),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // ---- control ----
    assign w_accept   = i_in_valid & (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_move_out = (r_state == S_DONE) & (~r_out_valid | ~i_out_stall);

    assign w_cap_ext = CMP_W'(r_capacity);
    assign w_limit   = (w_cap_ext < CMP_W'(SET_DEPTH)) ? w_cap_ext : CMP_W'(SET_DEPTH);
    assign w_full    = (CMP_W'(r_count) >= w_limit);
    assign w_val     = r_key;
    // hit flag at the row's end is complete once the state leaves the scan
    assign w_insert  = (r_state == S_UPDATE) & (r_kind == KIND_INSERT) & ~w_full &
                       ~w_probe[SET_DEPTH].hit;

    always_comb begin
        n_state     = r_state;
        n_scan      = r_scan;
        n_count     = r_count;
        n_sum       = r_sum;
        n_min       = r_min;
        n_max       = r_max;
        n_status    = r_status;
        n_found     = r_found;
        n_mean      = r_mean;
        n_out_valid = r_out_valid;

        if (o_out_valid & ~i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_scan  = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_scan = r_scan + 1'b1;
                if (r_scan == IDX_W'(SET_DEPTH - 1)) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_found = w_probe[SET_DEPTH].hit;
                if (r_kind == KIND_LOOKUP) begin
                    n_status = ST_LOOKUP;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else if (w_probe[SET_DEPTH].hit) begin
                    n_status = ST_DUP;
                end else begin
                    n_status = ST_INSERTED;
                end
                if (w_insert) begin
                    n_count = r_count + 1'b1;
                    n_sum   = r_sum + SUM_W'(w_val);
                    if (r_count == '0) begin
                        n_min = w_val;
                        n_max = w_val;
                    end else begin
                        if (w_val < r_min) n_min = w_val;
                        if (w_val > r_max) n_max = w_val;
                    end
                end
                if ((r_count == '0) & ~w_insert) begin
                    n_mean  = '0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIVGO;
                end
            end
            S_DIVGO: begin
                n_state = S_DIVWAIT;
            end
            S_DIVWAIT: begin
                if (w_div_done) begin
                    n_mean  = w_quot;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_move_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan      <= n_scan;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_min       <= n_min;
            r_max       <= n_max;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_found  <= n_found;
        r_mean   <= n_mean;
        if (w_accept) begin
            r_kind <= i_in_data.kind;
            r_key  <= i_in_data.value;
        end
        if (w_move_out) begin
            r_out.status        <= r_status;
            r_out.found         <= r_found;
            r_out.element_count <= CAP_W'(r_count);
            r_out.is_empty      <= (r_count == '0);
            r_out.mean_value    <= r_mean;
            r_out.spread        <= (r_count == '0) ? '0 : VAL_W'(r_max - r_min);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sim/tb_bounded_set_store_core.sv
// Self-checking testbench for bounded_set_store_core with a built-in set predictor.
module tb_bounded_set_store_core;
    import bss_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = SET_DEPTH + SUM_W + 16;
    localparam int HOLD_CYCLES  = 600;
    localparam int IDLE_PCT     = 34;
    localparam int MAX_REPORTS  = 10;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              in_valid    = 1'b0;
    logic              o_in_stall;
    t_in_item          in_data     = '0;
    logic              o_out_valid;
    logic              out_stall   = 1'b0;
    t_out_item         o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Predictor state
    logic [VAL_W-1:0]  held [0:SET_DEPTH-1];
    int unsigned       held_n    = 0;
    longint            sum_acc   = 0;
    longint            lo_val    = 0;
    longint            hi_val    = 0;
    logic [CAP_W-1:0]  cap_reg   = CAPACITY_RESET;

    t_out_item         reply_queue [$];
    int unsigned       bad_replies = 0;
    int unsigned       cycle_count = 0;
    int                hold_left   = 0;
    bit                steady_in   = 1'b0;
    bit                steady_out  = 1'b0;

    bounded_set_store_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver back-pressure: long hold when requested, else random or none.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_stall = 1'b1;
            hold_left--;
        end else if (steady_out) begin
            out_stall = 1'b0;
        end else begin
            out_stall = ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    function automatic t_out_item predict_set_reply(t_in_item it);
        t_out_item   r;
        logic        present;
        int unsigned lim;
        longint      v;
        present = 1'b0;
        v       = longint'(it.value);
        for (int i = 0; i < held_n; i++)
            if (held[i] == it.value) present = 1'b1;
        lim = (cap_reg < SET_DEPTH) ? cap_reg : SET_DEPTH;
        if (it.kind == KIND_LOOKUP) begin
            r.status = ST_LOOKUP;
        end else if (held_n >= lim) begin
            r.status = ST_FULL;  // full wins over duplicate
        end else if (present) begin
            r.status = ST_DUP;
        end else begin
            r.status = ST_INSERTED;
            held[held_n] = it.value;
            if (held_n == 0) begin
                lo_val = v;
                hi_val = v;
            end else begin
                if (v < lo_val) lo_val = v;
                if (v > hi_val) hi_val = v;
            end
            held_n++;
            sum_acc += v;
        end
        r.found         = present;
        r.element_count = held_n[CAP_W-1:0];
        r.is_empty      = (held_n == 0);
        r.mean_value    = (held_n > 0) ? VAL_W'(sum_acc / longint'(held_n)) : '0;
        r.spread        = (held_n > 0) ? VAL_W'(hi_val - lo_val) : '0;
        return r;
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (reply_queue.size() == 0) begin
                bad_replies++;
                if (bad_replies <= MAX_REPORTS)
                    $display("unexpected transaction: status=%0d count=%0d",
                             o_out_data.status, o_out_data.element_count);
            end else begin
                want = reply_queue.pop_front();
                if (o_out_data.status !== want.status ||
                    o_out_data.found !== want.found ||
                    o_out_data.element_count !== want.element_count ||
                    o_out_data.is_empty !== want.is_empty ||
                    o_out_data.mean_value !== want.mean_value ||
                    o_out_data.spread !== want.spread) begin
                    bad_replies++;
                    if (bad_replies <= MAX_REPORTS) begin
                        $write("mismatch at cycle %0d: exp st=%0d fnd=%0d cnt=%0d emp=%0d",
                               cycle_count, want.status, want.found,
                               want.element_count, want.is_empty);
                        $write(" mean=%0d spr=%h / got st=%0d fnd=%0d cnt=%0d emp=%0d",
                               want.mean_value, want.spread, o_out_data.status,
                               o_out_data.found, o_out_data.element_count,
                               o_out_data.is_empty);
                        $display(" mean=%0d spr=%h",
                                 o_out_data.mean_value, o_out_data.spread);
                    end
                end
            end
        end
    end

    function automatic t_in_item make_item(logic kind, logic signed [VAL_W-1:0] v);
        t_in_item it;
        it.kind  = kind;
        it.value = v;
        return it;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20 && held_n > 0) return held[$urandom_range(0, held_n - 1)];
        if (r < 35) begin
            case ($urandom_range(0, 4))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return 32'sd0;
                3:       return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        if (r < 60) return $signed(VAL_W'($urandom_range(0, 40))) - 32'sd20;
        return $urandom;
    endfunction

    function automatic t_in_item random_item();
        return make_item(($urandom_range(0, 99) < 60) ? KIND_INSERT : KIND_LOOKUP,
                         pick_value());
    endfunction

    task automatic send_item(t_in_item it);
        if (!steady_in) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                @(negedge i_clk);
                in_valid = 1'b0;
            end
        end
        @(negedge i_clk);
        in_valid = 1'b1;
        in_data  = it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        reply_queue.push_back(predict_set_reply(it));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (reply_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(int unsigned cap);
        wait_idle();
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {REG_CAPACITY, 2'b00};
        pwdata  = DATA_W'(cap);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        cap_reg = cap[CAP_W-1:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic test_empty_set();
        send_item(make_item(KIND_LOOKUP, 32'sd0));
        write_capacity(0);
        send_item(make_item(KIND_INSERT, 32'sd5));  // refused full on an empty set
        send_item(make_item(KIND_LOOKUP, 32'sd5));
    endtask

    task automatic test_extremes();
        write_capacity(2);
        send_item(make_item(KIND_INSERT, VAL_MIN));  // first insert sets min and max
        send_item(make_item(KIND_LOOKUP, VAL_MIN));
        send_item(make_item(KIND_INSERT, VAL_MIN));
        send_item(make_item(KIND_INSERT, VAL_MAX));  // widest spread
        send_item(make_item(KIND_INSERT, 32'sd7));
        send_item(make_item(KIND_INSERT, VAL_MAX));  // full and duplicate at once
        send_item(make_item(KIND_LOOKUP, 32'sd7));
    endtask

    task automatic test_mean_truncation();
        write_capacity(127);                         // beyond depth, clipped to 64
        send_item(make_item(KIND_INSERT, -32'sd3));
        send_item(make_item(KIND_INSERT, -32'sd4));
        send_item(make_item(KIND_INSERT, 32'sd100));
        send_item(make_item(KIND_LOOKUP, -32'sd4));
        send_item(make_item(KIND_LOOKUP, -32'sd1));
    endtask

    task automatic test_random_phase(int unsigned cap, int n);
        write_capacity(cap);
        repeat (n) send_item(random_item());
    endtask

    task automatic test_full_rate();
        write_capacity(50);
        steady_in  = 1'b1;
        steady_out = 1'b1;
        repeat (100) send_item(random_item());
        steady_in  = 1'b0;
        steady_out = 1'b0;
    endtask

    task automatic test_backpressure();
        write_capacity(64);
        steady_in = 1'b1;
        @(posedge i_clk);
        hold_left = HOLD_CYCLES;
        repeat (30) send_item(random_item());
        steady_in = 1'b0;
    endtask

    task automatic test_shrunk_capacity();
        write_capacity(3);                           // below the current count
        repeat (120) send_item(random_item());
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_set();
        test_extremes();
        test_mean_truncation();
        test_random_phase(12, 120);
        test_random_phase(24, 120);
        test_random_phase(40, 120);
        test_full_rate();
        test_backpressure();
        test_random_phase(64, 150);
        test_random_phase(127, 150);
        test_shrunk_capacity();

        wait_idle();
        if (bad_replies == 0 && reply_queue.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/bss_pkg.sv
sv/bss_cell.sv
sv/bss_divider.sv
sv/bounded_set_store_core.sv
sim/tb_bounded_set_store_core.sv
